// ===== hw/rtl/kea_pkg.sv =====
// shared types and constants of the kruskal edge acceptor
`timescale 1ns / 1ps

package kea_pkg;

  localparam int RANK_BITS  = 4;
  localparam int TOTAL_BITS = 24;
  localparam int CFG_BITS   = 9;

  localparam logic [RANK_BITS-1:0]  RANK_MAX  = 4'd15;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 24'hFF_FFFF;
  localparam logic [CFG_BITS-1:0]   NODE_COUNT_RESET = 9'd256;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_ORDER = 2'd2;

  // requests from the edge controller to the forest unit
  typedef struct packed {
    logic union_go;
    logic clear_go;
  } forest_cmd_t;

  // forest unit status back to the edge controller
  typedef struct packed {
    logic ready;
    logic done;
    logic joined;
  } forest_rsp_t;

endpackage

// ===== hw/rtl/kea_forest.sv =====
// union-find forest: parent/rank memory with a find, compress and link sequencer
`timescale 1ns / 1ps

module kea_forest
  import kea_pkg::*;
#(
  parameter int MAX_NODES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  forest_cmd_t                   cmd,
  input  logic [$clog2(MAX_NODES)-1:0]  node_a,
  input  logic [$clog2(MAX_NODES)-1:0]  node_b,
  output forest_rsp_t                   rsp
);

  localparam int NW = $clog2(MAX_NODES);
  localparam logic [NW-1:0] LAST_IDX = NW'(MAX_NODES - 1);

  typedef struct packed {
    logic [RANK_BITS-1:0] rank;
    logic [NW-1:0]        parent;
  } word_t;

  typedef enum logic [2:0] {
    F_CLEAR,
    F_IDLE,
    F_WALK,
    F_COMP,
    F_LINK,
    F_BUMP
  } fstate_t;

  word_t mem [MAX_NODES];
  word_t rd_word_r;

  fstate_t              state_r, state_nxt;
  logic                 side_r, side_nxt;
  logic [NW-1:0]        cur_r, cur_nxt;
  logic [NW-1:0]        start_r, start_nxt;
  logic [NW-1:0]        node_b_r, node_b_nxt;
  logic [NW-1:0]        root_a_r, root_a_nxt;
  logic [NW-1:0]        root_b_r, root_b_nxt;
  logic [RANK_BITS-1:0] rank_a_r, rank_a_nxt;
  logic [RANK_BITS-1:0] rank_b_r, rank_b_nxt;
  logic [NW-1:0]        clr_r, clr_nxt;
  logic                 done_r, done_nxt;
  logic                 joined_r, joined_nxt;

  logic [NW-1:0]        rd_addr;
  logic                 wr_en;
  logic [NW-1:0]        wr_addr;
  word_t                wr_data;
  logic                 fin;
  logic [NW-1:0]        fin_root;
  logic [NW-1:0]        root_sel;

  always_comb begin
    state_nxt  = state_r;
    side_nxt   = side_r;
    cur_nxt    = cur_r;
    start_nxt  = start_r;
    node_b_nxt = node_b_r;
    root_a_nxt = root_a_r;
    root_b_nxt = root_b_r;
    rank_a_nxt = rank_a_r;
    rank_b_nxt = rank_b_r;
    clr_nxt    = clr_r;
    done_nxt   = 1'b0;
    joined_nxt = joined_r;
    rd_addr    = cur_r;
    wr_en      = 1'b0;
    wr_addr    = cur_r;
    wr_data    = '0;
    fin        = 1'b0;
    fin_root   = cur_r;
    root_sel   = side_r ? root_b_r : root_a_r;

    case (state_r)
      F_CLEAR: begin
        wr_en          = 1'b1;
        wr_addr        = clr_r;
        wr_data.rank   = '0;
        wr_data.parent = clr_r;
        clr_nxt        = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = F_IDLE;
        end
      end
      F_IDLE: begin
        if (cmd.clear_go) begin
          clr_nxt   = '0;
          state_nxt = F_CLEAR;
        end else if (cmd.union_go) begin
          rd_addr    = node_a;
          cur_nxt    = node_a;
          start_nxt  = node_a;
          node_b_nxt = node_b;
          side_nxt   = 1'b0;
          state_nxt  = F_WALK;
        end
      end
      F_WALK: begin
        if (rd_word_r.parent == cur_r) begin
          // root reached, keep it and its rank
          if (side_r) begin
            root_b_nxt = cur_r;
            rank_b_nxt = rd_word_r.rank;
          end else begin
            root_a_nxt = cur_r;
            rank_a_nxt = rd_word_r.rank;
          end
          if (start_r == cur_r) begin
            fin      = 1'b1;
            fin_root = cur_r;
          end else begin
            rd_addr   = start_r;
            cur_nxt   = start_r;
            state_nxt = F_COMP;
          end
        end else begin
          rd_addr = rd_word_r.parent;
          cur_nxt = rd_word_r.parent;
        end
      end
      F_COMP: begin
        // point the node straight at the root, then step to its old parent
        wr_en          = 1'b1;
        wr_addr        = cur_r;
        wr_data.rank   = rd_word_r.rank;
        wr_data.parent = root_sel;
        if (rd_word_r.parent == root_sel) begin
          fin      = 1'b1;
          fin_root = root_sel;
        end else begin
          rd_addr = rd_word_r.parent;
          cur_nxt = rd_word_r.parent;
        end
      end
      F_LINK: begin
        if (rank_a_r > rank_b_r) begin
          wr_en          = 1'b1;
          wr_addr        = root_b_r;
          wr_data.rank   = rank_b_r;
          wr_data.parent = root_a_r;
          done_nxt       = 1'b1;
          joined_nxt     = 1'b1;
          state_nxt      = F_IDLE;
        end else begin
          wr_en          = 1'b1;
          wr_addr        = root_a_r;
          wr_data.rank   = rank_a_r;
          wr_data.parent = root_b_r;
          if (rank_a_r == rank_b_r && rank_b_r != RANK_MAX) begin
            state_nxt = F_BUMP;
          end else begin
            done_nxt   = 1'b1;
            joined_nxt = 1'b1;
            state_nxt  = F_IDLE;
          end
        end
      end
      F_BUMP: begin
        wr_en          = 1'b1;
        wr_addr        = root_b_r;
        wr_data.rank   = rank_b_r + 1'b1;
        wr_data.parent = root_b_r;
        done_nxt       = 1'b1;
        joined_nxt     = 1'b1;
        state_nxt      = F_IDLE;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase

    // end of one find: start the second endpoint or decide the link
    if (fin) begin
      if (!side_r) begin
        side_nxt  = 1'b1;
        rd_addr   = node_b_r;
        cur_nxt   = node_b_r;
        start_nxt = node_b_r;
        state_nxt = F_WALK;
      end else if (fin_root == root_a_r) begin
        done_nxt   = 1'b1;
        joined_nxt = 1'b0;
        state_nxt  = F_IDLE;
      end else begin
        state_nxt = F_LINK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_CLEAR;
      clr_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      done_r  <= done_nxt;
    end
    side_r   <= side_nxt;
    cur_r    <= cur_nxt;
    start_r  <= start_nxt;
    node_b_r <= node_b_nxt;
    root_a_r <= root_a_nxt;
    root_b_r <= root_b_nxt;
    rank_a_r <= rank_a_nxt;
    rank_b_r <= rank_b_nxt;
    joined_r <= joined_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_word_r <= mem[rd_addr];
  end

  assign rsp.ready  = (state_r == F_IDLE);
  assign rsp.done   = done_r;
  assign rsp.joined = joined_r;

endmodule

// ===== hw/rtl/kruskal_edge_acceptor_core.sv =====
// top level of the kruskal edge acceptor: edge checks, forest weight and result register
`timescale 1ns / 1ps

// Edge acceptor for a minimum spanning forest. Edges come in one transaction at a
// time, sorted by nondecreasing weight; each gives exactly one result transaction
// with the accept flag, the running forest weight, a status code and graph_done.
// The union-find forest (parent and rank per node) sits in one single-port-write
// memory of MAX_NODES words; a small sequencer walks it one memory read per cycle.
// An in-range edge runs a find for each endpoint: a walk up to the root, then path
// compression that points the walked nodes straight at it. If the two roots differ,
// a link follows, which also raises the new root's rank when both ranks are equal
// and below the maximum; with compression the trees stay shallow. An out-of-range
// edge never reaches the forest. After reset and after every edge marked last, the
// memory is swept back to its initial forest, during which no edge is taken;
// configuration writes are always taken. The result sits in an output register, so
// the work on an edge does not wait for the consumer; only the hand-off of the next
// result does.
module kruskal_edge_acceptor_core
  import kea_pkg::*;
#(
  parameter int MAX_NODES   = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel (node_count)
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_BITS-1:0]   cfg_data,
  // edge channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_node_u,
  input  logic [7:0]            in_node_v,
  input  logic [15:0]           in_edge_weight,
  input  logic                  in_last_edge,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_accepted,
  output logic [TOTAL_BITS-1:0] out_forest_weight,
  output logic [1:0]            out_status,
  output logic                  out_graph_done
);

  localparam int NW  = $clog2(MAX_NODES);
  // compare width wide enough for node_count and MAX_NODES itself
  localparam int LW0 = $clog2(MAX_NODES + 1);
  localparam int LW  = (LW0 > CFG_BITS) ? LW0 : CFG_BITS;
  // only the low WEIGHT_BITS of the 16-bit weight count
  localparam int WB  = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam logic [LW-1:0] MAX_NODES_L = LW'(MAX_NODES);

  typedef enum logic [1:0] {
    T_IDLE,
    T_FIND,
    T_OUT
  } tstate_t;

  tstate_t                state_r;
  logic [CFG_BITS-1:0]    node_count_r;
  logic [TOTAL_BITS-1:0]  total_r;
  logic [WB-1:0]          prev_r;
  logic [WB-1:0]          weight_r;
  logic                   last_r;
  logic                   acc_r;
  logic [1:0]             status_r;

  logic                   out_valid_r;
  logic                   out_accepted_r;
  logic [TOTAL_BITS-1:0]  out_forest_weight_r;
  logic [1:0]             out_status_r;
  logic                   out_graph_done_r;

  forest_cmd_t            fcmd;
  forest_rsp_t            frsp;

  logic [LW-1:0]          limit;
  logic                   in_range;
  logic [WB-1:0]          in_weight;
  logic                   in_fire;
  logic                   out_free;
  logic                   out_load;
  logic [TOTAL_BITS:0]    total_sum;
  logic [TOTAL_BITS-1:0]  total_sat;

  // node_count above MAX_NODES saturates, zero puts every node out of range
  assign limit = (LW'(node_count_r) < MAX_NODES_L) ? LW'(node_count_r) : MAX_NODES_L;
  assign in_range  = (LW'(in_node_u) < limit) && (LW'(in_node_v) < limit);
  assign in_weight = in_edge_weight[WB-1:0];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == T_IDLE) && frsp.ready;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  // the finished edge moves into the output register
  assign out_load  = (state_r == T_OUT) && out_free;

  // saturating forest weight, one wide add
  assign total_sum = {1'b0, total_r} + (TOTAL_BITS + 1)'(weight_r);
  assign total_sat = total_sum[TOTAL_BITS] ? TOTAL_MAX : total_sum[TOTAL_BITS-1:0];

  // a rejected endpoint never reaches the forest
  assign fcmd.union_go = in_fire && in_range;
  // sweep the forest once the last edge's result is handed to the output register
  assign fcmd.clear_go = out_load && last_r;

  kea_forest #(
    .MAX_NODES (MAX_NODES)
  ) u_forest (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (fcmd),
    .node_a (NW'(in_node_u)),
    .node_b (NW'(in_node_v)),
    .rsp    (frsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      node_count_r <= NODE_COUNT_RESET;
      total_r      <= '0;
      prev_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_data;
      end

      // result register: load a new transaction or hand the current one off
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        T_IDLE: begin
          if (in_fire) begin
            weight_r <= in_weight;
            last_r   <= in_last_edge;
            acc_r    <= 1'b0;
            if (!in_range) begin
              // out of range: forest and previous weight untouched
              status_r <= STATUS_RANGE;
              state_r  <= T_OUT;
            end else begin
              // order violation is only reported, the edge still counts
              status_r <= (in_weight < prev_r) ? STATUS_ORDER : STATUS_OK;
              prev_r   <= in_weight;
              state_r  <= T_FIND;
            end
          end
        end
        T_FIND: begin
          if (frsp.done) begin
            acc_r <= frsp.joined;
            if (frsp.joined) begin
              total_r <= total_sat;
            end
            state_r <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_free) begin
            out_accepted_r      <= acc_r;
            out_forest_weight_r <= total_r;
            out_status_r        <= status_r;
            out_graph_done_r    <= last_r;
            if (last_r) begin
              // graph closed: totals go back to zero with the forest
              total_r <= '0;
              prev_r  <= '0;
            end
            state_r <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_accepted_r;
  assign out_forest_weight = out_forest_weight_r;
  assign out_status        = out_status_r;
  assign out_graph_done    = out_graph_done_r;

endmodule
